// ----- rtl/bele_pkg.sv -----
// Shared constants and character lookup functions for the byte escape encoder.
// No dependencies.
package bele_pkg;

  localparam int unsigned COLUMN_BITS_DEF = 16;
  localparam int unsigned LINE_LEN_W      = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned TOKEN_MAX       = 5;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_BREAKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_QUOTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEX_ESCAPES    = 2'd3;

  localparam logic [6:0] CHAR_NL        = 7'h0A;
  localparam logic [6:0] CHAR_BACKSLASH = 7'h5C;
  localparam logic [6:0] CHAR_X         = 7'h78;
  localparam logic [6:0] CHAR_ZERO      = 7'h30;

  // lowercase hex digit for a nibble
  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'd0, nib};
    end else begin
      c = 7'h57 + {3'd0, nib};
    end
    return c;
  endfunction

  // escape letter for control codes 0x07..0x0D, indexed from 0x07
  function automatic logic [6:0] ctrl_letter(input logic [2:0] idx);
    logic [6:0] c;
    case (idx)
      3'd0: c = 7'h61; // a
      3'd1: c = 7'h62; // b
      3'd2: c = 7'h74; // t
      3'd3: c = 7'h6E; // n
      3'd4: c = 7'h76; // v
      3'd5: c = 7'h66; // f
      3'd6: c = 7'h72; // r
      default: c = 7'h3F;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/byte_escape_line_wrap_encoder.sv -----
// Byte escape encoder with line wrapping: top level.
// Depends on bele_pkg.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_byte             | sink
//   result  | out_valid, out_stall, out_char, out_last| source
//   config  | cfg_we, cfg_index, cfg_wdata            | sink
//
// An input transaction is rendered into a token buffer of up to five characters
// in the cycle it is accepted; characters then leave through the output register
// one per cycle while out_stall is low; a dropped forced break yields none.
// The next byte is taken while the last character of the current one moves out.
// Reset (rst_n low, synchronous) clears column, line-end flag, registers and valids.
// A stall on the result side holds the output register and backs up the input.
module byte_escape_line_wrap_encoder
  import bele_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [6:0]            out_char,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LINE_LEN_W-1:0] cfg_wdata
);

  localparam int unsigned SUM_W = ((COLUMN_BITS > LINE_LEN_W) ? COLUMN_BITS : LINE_LEN_W) + 1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

  logic [LINE_LEN_W-1:0]  line_len_r;
  logic                   nl_breaks_r, esc_quotes_r, hex_esc_r;
  logic [COLUMN_BITS-1:0] column_r, column_nxt;
  logic                   at_end_r, at_end_nxt;

  logic [TOKEN_MAX-1:0][6:0] tok_r, tok_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [6:0]                out_char_r, out_char_nxt;
  logic                      out_last_r, out_last_nxt;

  logic       is_quote, is_ctrl, special, is_fnl, use_hex, wrap_on, brk;
  logic [2:0] width, blen;
  logic [3:0][6:0] body;
  logic [SUM_W-1:0] sum;
  logic [COLUMN_BITS-1:0] col_new;
  logic [TOKEN_MAX-1:0][6:0] tok_new;
  logic [2:0] cnt_new;
  logic       buf_empty, out_load, buf_pop, in_acc;

  // token rendering
  always_comb begin
    is_quote = esc_quotes_r && (in_byte inside {8'h22, 8'h27, 8'h3F});
    is_ctrl  = in_byte inside {[8'h07:8'h0D]};
    special  = (in_byte == 8'h00) || is_ctrl || (in_byte == 8'h5C) || is_quote;
    is_fnl   = (in_byte == {1'b0, CHAR_NL}) && nl_breaks_r;
    use_hex  = (special && hex_esc_r) || (!special && ((in_byte < 8'h20) || (in_byte > 8'h7E)));
    wrap_on  = (line_len_r != '0);

    body = '0;
    if (is_fnl) begin
      body[0] = CHAR_NL;
      blen    = (wrap_on && !at_end_r) ? 3'd1 : 3'd0;
      width   = 3'd0;
    end else if (use_hex) begin
      body  = {hex_digit(in_byte[3:0]), hex_digit(in_byte[7:4]), CHAR_X, CHAR_BACKSLASH};
      blen  = 3'd4;
      width = 3'd4;
    end else if (special) begin
      body[0] = CHAR_BACKSLASH;
      if (in_byte == 8'h00) begin
        body[1] = CHAR_ZERO;
      end else if (is_ctrl) begin
        body[1] = ctrl_letter(3'(in_byte - 8'h07));
      end else begin
        body[1] = in_byte[6:0];
      end
      blen  = 3'd2;
      width = 3'd2;
    end else begin
      body[0] = in_byte[6:0];
      blen    = 3'd1;
      width   = 3'd1;
    end

    sum = SUM_W'(column_r) + SUM_W'(width);
    brk = wrap_on && !is_fnl && (sum > SUM_W'(line_len_r));
    if (brk) begin
      col_new = COLUMN_BITS'(width);
    end else if (sum > SUM_W'(COL_MAX)) begin
      col_new = COL_MAX;
    end else begin
      col_new = sum[COLUMN_BITS-1:0];
    end

    tok_new = brk ? {body, CHAR_NL} : {7'h00, body};
    cnt_new = blen + {2'd0, brk};
  end

  // handshake and buffer control
  always_comb begin
    buf_empty = (cnt_r == 3'd0);
    out_load  = !out_valid_r || !out_stall;
    buf_pop   = out_load && !buf_empty;
    in_stall  = !(buf_empty || ((cnt_r == 3'd1) && buf_pop));
    in_acc    = in_valid && !in_stall;

    tok_nxt       = tok_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    column_nxt    = column_r;
    at_end_nxt    = at_end_r;

    if (buf_pop) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = tok_r[0];
      out_last_nxt  = (cnt_r == 3'd1);
      tok_nxt       = {7'h00, tok_r[TOKEN_MAX-1:1]};
      cnt_nxt       = cnt_r - 3'd1;
    end else if (out_load) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      tok_nxt = tok_new;
      cnt_nxt = cnt_new;
      if (is_fnl) begin
        if (wrap_on && !at_end_r) begin
          at_end_nxt = 1'b1;
          column_nxt = '0;
        end
      end else if (wrap_on) begin
        at_end_nxt = brk;
        column_nxt = col_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r   <= '0;
      nl_breaks_r  <= 1'b0;
      esc_quotes_r <= 1'b0;
      hex_esc_r    <= 1'b0;
      column_r     <= '0;
      at_end_r     <= 1'b0;
      cnt_r        <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_LENGTH:    line_len_r   <= cfg_wdata;
          REG_NEWLINE_BREAKS: nl_breaks_r  <= cfg_wdata[0];
          REG_ESCAPE_QUOTES:  esc_quotes_r <= cfg_wdata[0];
          REG_HEX_ESCAPES:    hex_esc_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      column_r    <= column_nxt;
      at_end_r    <= at_end_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r      <= tok_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ----- rtl/bele_checker.sv -----
// Port-level assertions for the byte escape encoder, bound to the top level.
// Depends on bele_pkg and byte_escape_line_wrap_encoder.
module bele_checker
  import bele_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_char,
  input logic       out_last
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a token in progress follows without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a token");

  a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !out_last |-> in_stall)
    else $error("input taken while token pending");

  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char >= 7'h20) && (out_char <= 7'h7E)) || (out_char == CHAR_NL))
    else $error("non-printable output character");

endmodule

bind byte_escape_line_wrap_encoder bele_checker u_bele_checker (.*);

// ----- bench/escape_stream_checker.sv -----
// Escape stream checker: follows register writes, predicts the characters each
// accepted byte yields and compares them with the result channel.
// Depends on bele_pkg.
module escape_stream_checker
  import bele_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [6:0]            out_char,
  input  logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LINE_LEN_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [7:0] BYTE_NUL       = 8'h00;
  localparam logic [7:0] BYTE_BEL       = 8'h07;
  localparam logic [7:0] BYTE_BS        = 8'h08;
  localparam logic [7:0] BYTE_TAB       = 8'h09;
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_VT        = 8'h0B;
  localparam logic [7:0] BYTE_FF        = 8'h0C;
  localparam logic [7:0] BYTE_CR        = 8'h0D;
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_DQUOTE    = 8'h22;
  localparam logic [7:0] BYTE_SQUOTE    = 8'h27;
  localparam logic [7:0] BYTE_QMARK     = 8'h3F;
  localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
  localparam logic [7:0] BYTE_TILDE     = 8'h7E;
  localparam logic [COLUMN_BITS_DEF:0] COLUMN_CAP = {1'b0, {COLUMN_BITS_DEF{1'b1}}};

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } out_char_t;

  out_char_t                  expected_chars [$];
  logic [LINE_LEN_W-1:0]      line_len   = '0;
  logic                       nl_breaks  = 1'b0;
  logic                       esc_quotes = 1'b0;
  logic                       hex_mode   = 1'b0;
  logic [COLUMN_BITS_DEF-1:0] column     = '0;
  logic                       at_eol     = 1'b0;

  task automatic emit(input logic [7:0] c);
    out_char_t item;
    item.ch   = c[6:0];
    item.last = 1'b0;
    expected_chars.push_back(item);
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h61 + {4'd0, n} - 8'd10;
  endfunction

  // width is the token's column count: 1, 2 or 4
  task automatic wrap_for_token(input int unsigned width);
    logic [COLUMN_BITS_DEF:0] sum;
    if (line_len != '0) begin
      sum = (COLUMN_BITS_DEF+1)'(column) + (COLUMN_BITS_DEF+1)'(width);
      if (sum > (COLUMN_BITS_DEF+1)'(line_len)) begin
        emit({1'b0, CHAR_NL});
        at_eol = 1'b1;
        sum = (COLUMN_BITS_DEF+1)'(width);
      end else begin
        at_eol = 1'b0;
      end
      column = (sum > COLUMN_CAP) ? '1 : sum[COLUMN_BITS_DEF-1:0];
    end
  endtask

  task automatic render_byte(input logic [7:0] b);
    int        first;
    logic      quote;
    logic      ctrl;
    logic      special;
    out_char_t tail;
    first   = expected_chars.size();
    quote   = esc_quotes && (b == BYTE_DQUOTE || b == BYTE_SQUOTE || b == BYTE_QMARK);
    ctrl    = (b >= BYTE_BEL) && (b <= BYTE_CR);
    special = (b == BYTE_NUL) || ctrl || (b == BYTE_BACKSLASH) || quote;
    if (b == BYTE_LF && nl_breaks) begin
      // forced break, dropped right after a break or with wrapping off
      if (line_len != '0 && !at_eol) begin
        emit({1'b0, CHAR_NL});
        at_eol = 1'b1;
        column = '0;
      end
    end else if ((special && hex_mode) || (!special && (b < BYTE_SPACE || b > BYTE_TILDE))) begin
      wrap_for_token(4);
      emit({1'b0, CHAR_BACKSLASH});
      emit({1'b0, CHAR_X});
      emit(hex_ascii(b[7:4]));
      emit(hex_ascii(b[3:0]));
    end else if (special) begin
      wrap_for_token(2);
      emit({1'b0, CHAR_BACKSLASH});
      if (b == BYTE_NUL) begin
        emit({1'b0, CHAR_ZERO});
      end else if (ctrl) begin
        case (b)
          BYTE_BEL: emit("a");
          BYTE_BS:  emit("b");
          BYTE_TAB: emit("t");
          BYTE_LF:  emit("n");
          BYTE_VT:  emit("v");
          BYTE_FF:  emit("f");
          default:  emit("r");
        endcase
      end else begin
        emit(b);
      end
    end else begin
      wrap_for_token(1);
      emit(b);
    end
    if (expected_chars.size() > first) begin
      tail = expected_chars.pop_back();
      tail.last = 1'b1;
      expected_chars.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    out_char_t want;
    if (!rst_n) begin
      line_len   = '0;
      nl_breaks  = 1'b0;
      esc_quotes = 1'b0;
      hex_mode   = 1'b0;
      column     = '0;
      at_eol     = 1'b0;
      fail_count = 0;
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected transaction: out_char %h out_last %b", out_char, out_last);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_char);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, actual %b", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        render_byte(in_byte);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_LENGTH:    line_len   = cfg_wdata;
          REG_NEWLINE_BREAKS: nl_breaks  = cfg_wdata[0];
          REG_ESCAPE_QUOTES:  esc_quotes = cfg_wdata[0];
          REG_HEX_ESCAPES:    hex_mode   = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending = expected_chars.size();
  end

endmodule

// ----- bench/tb_byte_escape_line_wrap_encoder.sv -----
// Testbench top for byte_escape_line_wrap_encoder: drives bytes and register
// settings with random gaps and stalls, and gives the verdict.
// Depends on bele_pkg, byte_escape_line_wrap_encoder and escape_stream_checker.
module tb_byte_escape_line_wrap_encoder;
  import bele_pkg::*;

  localparam int HOLD_OFF_CYCLES = 120;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int PHASE_ITEMS     = 30;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_byte   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [6:0]            out_char;
  logic                  out_last;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LINE_LEN_W-1:0] cfg_wdata = '0;

  int   fail_count;
  int   pending;
  int   idle_cycles   = 0;
  int   burst_left    = 0;
  logic pressure_req  = 1'b0;
  logic pressure_done = 1'b0;

  // NUL and the control codes 0x07..0x0D, the escapable characters and the printable edges
  logic [7:0] boundary_bytes [17] = '{
    8'h00, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h5C,
    8'h22, 8'h27, 8'h3F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF
  };
  // forced breaks, two dropped after a break and one after a wrap
  logic [7:0] break_bytes [9] = '{
    8'h0A, 8'h0A, 8'h22, 8'h41, 8'h0A, 8'h0A, 8'h00, 8'h3F, 8'h0A
  };

  byte_escape_line_wrap_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  escape_stream_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, free stretches, and one long hold-off
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (pressure_req && !pressure_done) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      n = pick_gap();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      repeat (n) begin
        if (pressure_req && !pressure_done) break;
        @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (pressure_req && !pressure_done) begin
      gap = 0;
    end else if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_byte  = 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
  endtask

  // a suppressed break yields nothing, so the drain covers a byte still in flight
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LINE_LEN_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic configure(input logic [15:0] ll, input logic nl, input logic eq,
                           input logic hx);
    logic [14:0] junk;
    settle();
    write_reg(REG_LINE_LENGTH, ll);
    junk = 15'($urandom);
    write_reg(REG_NEWLINE_BREAKS, {junk, nl});
    junk = 15'($urandom);
    write_reg(REG_ESCAPE_QUOTES, {junk, eq});
    junk = 15'($urandom);
    write_reg(REG_HEX_ESCAPES, {junk, hx});
  endtask

  task automatic run_phase(input logic [15:0] ll, input logic nl, input logic eq,
                           input logic hx, input logic hold);
    logic [7:0] b;
    int         r;
    configure(ll, nl, eq, hx);
    repeat (PHASE_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        b = 8'($urandom_range(8'h20, 8'h7E));
      end else if (r < 6) begin
        case ($urandom_range(0, 6))
          0: b = 8'h00;
          1: b = 8'($urandom_range(8'h07, 8'h0D));
          2: b = 8'h5C;
          3: b = 8'h22;
          4: b = 8'h27;
          5: b = 8'h3F;
          default: b = 8'h0A;
        endcase
      end else begin
        b = 8'($urandom);
      end
      send_byte(b);
      if (hold) pressure_req = 1'b1;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (boundary_bytes[i]) send_byte(boundary_bytes[i]);
    configure(16'd5, 1'b1, 1'b1, 1'b1);
    foreach (break_bytes[i]) send_byte(break_bytes[i]);

    run_phase(16'd1,     1'b1, 1'b1, 1'b1, 1'b0);
    run_phase(16'd65531, 1'b0, 1'b0, 1'b0, 1'b1);
    run_phase(16'd0,     1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(16'd3,     1'b1, 1'b0, 1'b1, 1'b0);
    run_phase(16'd8,     1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(16'd4,     1'b0, 1'b1, 1'b1, 1'b0);
    run_phase(16'd80,    1'b1, 1'b0, 1'b0, 1'b0);
    repeat (3) begin
      run_phase(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65531)
                                                 : $urandom_range(0, 12)),
                1'($urandom), 1'($urandom), 1'($urandom), 1'b0);
    end
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
